// File: rtl/forest_fire_automaton_step_assert.svh
// Assertion macros for the forest fire step block.
// Both expect i_clk and i_rst_n in the scope of the user.
`ifndef FOREST_FIRE_AUTOMATON_STEP_ASSERT_SVH
`define FOREST_FIRE_AUTOMATON_STEP_ASSERT_SVH

// Same-cycle implication.
`define FFA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ffa_pkg.sv
`default_nettype none

package ffa_pkg;

    localparam int MAX_COLS  = 32;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CNT_W     = $clog2(MAX_COLS + 1);
    localparam int ADDR_W    = COL_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int THR_W     = 16;
    localparam int COLS_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH    = 2;

    localparam logic [THR_W-1:0]  GROW_THR_RST = THR_W'(3277);  // 0.05 of full scale
    localparam logic [THR_W-1:0]  IGN_THR_RST  = THR_W'(2621);  // 0.04 of full scale
    localparam logic [COLS_W-1:0] COLS_RST     = COLS_W'(32);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_TREE  = 2'd1,
        ST_BURN  = 2'd2
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROW   = 2'd0,
        CFG_IGNITE = 2'd1,
        CFG_COLS   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]  grow_thr;
        logic [THR_W-1:0]  ign_thr;
        logic [COLS_W-1:0] cols;
    } t_cfg;

    // Classified cell handed from front to engine.
    typedef struct packed {
        t_state st;
        logic   ok;
        logic   last;
    } t_item;

    // Line store entry.
    typedef struct packed {
        logic   above;
        logic   ok;
        t_state st;
    } t_entry;

    typedef struct packed {
        logic flushing;
        logic done_push;
    } t_bstat;

    function automatic logic burns(input t_entry e);
        return e.st == ST_BURN;
    endfunction

    function automatic t_state next_of(input t_entry e, input logic left,
                                       input logic right, input logic below);
        t_state ns;
        unique case (e.st)
            ST_EMPTY: ns = e.ok ? ST_TREE : ST_EMPTY;
            ST_TREE:  ns = (e.ok || e.above || left || right || below) ? ST_BURN : ST_TREE;
            default:  ns = ST_EMPTY;
        endcase
        return ns;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ffa_in_if.sv
`default_nettype none

interface ffa_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               cell_state;
    logic [ffa_pkg::THR_W-1:0] grow_draw;
    logic [ffa_pkg::THR_W-1:0] ignite_draw;
    logic                     frame_end;

    modport source (output valid, cell_state, grow_draw, ignite_draw, frame_end,
                    input ready);
    modport sink (input valid, cell_state, grow_draw, ignite_draw, frame_end,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/ffa_out_if.sv
`default_nettype none

interface ffa_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] next_state;
    logic       frame_done;

    modport source (output valid, next_state, frame_done, input ready);
    modport sink (input valid, next_state, frame_done, output ready);
endinterface

`default_nettype wire

// File: rtl/forest_fire_automaton_step.sv
// Path: a cell word passes the front register and the short queue, then the engine
//   (line store read, then update and store write); its result is the cell one row above.
// Flow: the engine takes no new cell until it has written the last one back, and waits
//   on a full output; the final-row flush after frame_end emits that row column by column.
// Reset: synchronous, active low; clears handshake and row/column state and loads the
//   default thresholds and row width; the line store is not cleared and needs no pass.
`default_nettype none
`include "forest_fire_automaton_step_assert.svh"

module forest_fire_automaton_step (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ffa_in_if.sink                               i_in,
    ffa_out_if.source                            o_out,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [ffa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ffa_pkg::THR_W-1:0]       i_cfg_data
);

    // Configuration registers: thresholds and row width.
    ffa_pkg::t_cfg  r_cfg;
    ffa_pkg::t_cfg  n_cfg;

    // Front-to-queue and queue-to-engine words.
    logic           w_push_valid;
    logic           w_push_ready;
    ffa_pkg::t_item w_push_item;
    logic           w_pop_valid;
    logic           w_pop_ready;
    ffa_pkg::t_item w_pop_item;
    ffa_pkg::t_bstat w_bstat;

    // Decode a register write; ignore indexes past the list.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (ffa_pkg::t_cfg_idx'(i_cfg_index))
                ffa_pkg::CFG_GROW:   n_cfg.grow_thr = i_cfg_data;
                ffa_pkg::CFG_IGNITE: n_cfg.ign_thr  = i_cfg_data;
                ffa_pkg::CFG_COLS:   n_cfg.cols     = i_cfg_data[ffa_pkg::COLS_W-1:0];
                default:             n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grow_thr <= ffa_pkg::GROW_THR_RST;
            r_cfg.ign_thr  <= ffa_pkg::IGN_THR_RST;
            r_cfg.cols     <= ffa_pkg::COLS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: take a cell word, fold its state code and run both draw tests.
    ffa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_item  (w_push_item)
    );

    // Short queue: lets the front keep taking words while the engine stalls or flushes.
    ffa_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_item  (w_push_item),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_item   (w_pop_item)
    );

    // Engine: two-bank line store, emit the row above, flush the last row on frame end.
    ffa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_pop_valid),
        .o_q_ready (w_pop_ready),
        .i_q_item  (w_pop_item),
        .o_out     (o_out),
        .o_stat    (w_bstat)
    );

    // An accepted cell word lands in the front register.
    `FFA_ASSERT_NEXT(a_front_load, i_in.valid && i_in.ready, w_push_valid, "front word lost")

    // Hold the queue while the last row drains.
    `FFA_ASSERT_IMPL(a_no_pop_in_flush, w_bstat.flushing, !(w_pop_valid && w_pop_ready),
        "queue popped during flush")

    // The frame-done word ends the flush and shows on the output.
    `FFA_ASSERT_NEXT(a_flush_ends, w_bstat.done_push,
        !w_bstat.flushing && o_out.valid && o_out.frame_done, "flush did not end")

endmodule

`default_nettype wire

// File: rtl/ffa_fifo.sv
`default_nettype none

module ffa_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire ffa_pkg::t_item i_push_item,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output ffa_pkg::t_item      o_pop_item
);

    localparam int PTR_W = (ffa_pkg::QDEPTH > 1) ? $clog2(ffa_pkg::QDEPTH) : 1;
    localparam int QC_W  = $clog2(ffa_pkg::QDEPTH + 1);

    ffa_pkg::t_item   r_buf [ffa_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [QC_W-1:0]  r_cnt;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;
    logic [QC_W-1:0]  n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_cnt != QC_W'(ffa_pkg::QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_buf[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == PTR_W'(ffa_pkg::QDEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == PTR_W'(ffa_pkg::QDEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ffa_front.sv
`default_nettype none

module ffa_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ffa_pkg::t_cfg i_cfg,
    ffa_in_if.sink             i_in,
    output logic               o_push_valid,
    input  wire logic          i_push_ready,
    output ffa_pkg::t_item     o_push_item
);

    logic           r_valid;
    ffa_pkg::t_item r_item;
    logic           n_valid;
    ffa_pkg::t_item n_item;
    logic           w_take;
    ffa_pkg::t_state w_st;

    assign i_in.ready   = !r_valid || i_push_ready;
    assign w_take       = i_in.valid && i_in.ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    // Fold the unused code into burning.
    always_comb begin
        unique case (ffa_pkg::t_state'(i_in.cell_state))
            ffa_pkg::ST_EMPTY: w_st = ffa_pkg::ST_EMPTY;
            ffa_pkg::ST_TREE:  w_st = ffa_pkg::ST_TREE;
            default:           w_st = ffa_pkg::ST_BURN;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (w_take) begin
            n_valid      = 1'b1;
            n_item.st    = w_st;
            n_item.last  = i_in.frame_end;
            n_item.ok    = ((w_st == ffa_pkg::ST_EMPTY) && (i_in.grow_draw <= i_cfg.grow_thr))
                        || ((w_st == ffa_pkg::ST_TREE) && (i_in.ignite_draw <= i_cfg.ign_thr));
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

`default_nettype wire

// File: rtl/ffa_back.sv
`default_nettype none

module ffa_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ffa_pkg::t_cfg  i_cfg,
    input  wire logic           i_q_valid,
    output logic                o_q_ready,
    input  wire ffa_pkg::t_item i_q_item,
    ffa_out_if.source           o_out,
    output ffa_pkg::t_bstat     o_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FREAD,
        S_FOUT
    } t_fsm;

    typedef enum logic [1:0] {
        ROWS_FIRST = 2'd0,
        ROWS_A     = 2'd1,
        ROWS_B     = 2'd2
    } t_rows;

    t_fsm                        r_state;
    t_fsm                        n_state;
    t_rows                       r_rows;
    t_rows                       n_rows;
    logic [ffa_pkg::COL_W-1:0]   r_col;
    logic [ffa_pkg::COL_W-1:0]   n_col;
    ffa_pkg::t_item              r_item;
    ffa_pkg::t_item              n_item;
    logic                        r_left;
    logic                        n_left;
    logic [ffa_pkg::COL_W-1:0]   r_x;
    logic [ffa_pkg::COL_W-1:0]   n_x;
    logic [ffa_pkg::COL_W-1:0]   r_fc;
    logic [ffa_pkg::COL_W-1:0]   n_fc;
    logic                        r_fbank;
    logic                        n_fbank;
    logic                        r_o_valid;
    logic                        n_o_valid;
    ffa_pkg::t_state             r_o_next;
    ffa_pkg::t_state             n_o_next;
    logic                        r_o_done;
    logic                        n_o_done;

    ffa_pkg::t_entry             r_mem [ffa_pkg::MEM_DEPTH];
    ffa_pkg::t_entry             r_rd0;
    ffa_pkg::t_entry             r_rd1;

    logic [ffa_pkg::CNT_W-1:0]   w_cols;
    logic [ffa_pkg::CNT_W-1:0]   w_c1;
    logic                        w_wbank;
    logic                        w_have_prev;
    logic                        w_flushing;
    logic                        w_out_free;
    logic                        w_we;
    ffa_pkg::t_entry             w_entry;
    logic [ffa_pkg::ADDR_W-1:0]  w_wa;
    logic [ffa_pkg::ADDR_W-1:0]  w_ra0;
    logic [ffa_pkg::ADDR_W-1:0]  w_ra1;
    logic                        w_rd_bank;
    logic [ffa_pkg::COL_W-1:0]   w_rd_col;

    // Clamp row width into two .. MAX_COLS.
    always_comb begin
        if (i_cfg.cols < ffa_pkg::COLS_W'(2)) begin
            w_cols = ffa_pkg::CNT_W'(2);
        end else if (i_cfg.cols > ffa_pkg::COLS_W'(ffa_pkg::MAX_COLS)) begin
            w_cols = ffa_pkg::CNT_W'(ffa_pkg::MAX_COLS);
        end else begin
            w_cols = ffa_pkg::CNT_W'(i_cfg.cols);
        end
    end

    assign w_c1        = ffa_pkg::CNT_W'(r_col) + ffa_pkg::CNT_W'(1);
    assign w_wbank     = (r_rows == ROWS_A);
    assign w_have_prev = (r_rows != ROWS_FIRST);
    assign w_flushing  = (r_state == S_FREAD) || (r_state == S_FOUT);
    assign w_out_free  = !r_o_valid || o_out.ready;

    // Read the row above during a row, the current row during a flush.
    assign w_rd_bank = w_flushing ? r_fbank : !w_wbank;
    assign w_rd_col  = w_flushing ? r_x : r_col;
    assign w_ra0     = {w_rd_bank, w_rd_col};
    assign w_ra1     = {w_rd_bank, w_rd_col + ffa_pkg::COL_W'(1)};
    assign w_wa      = {w_wbank, r_col};

    always_comb begin
        w_entry.st    = r_item.st;
        w_entry.ok    = r_item.ok;
        w_entry.above = w_have_prev && ffa_pkg::burns(r_rd0);
    end

    assign o_q_ready        = (r_state == S_IDLE);
    assign o_out.valid      = r_o_valid;
    assign o_out.next_state = r_o_next;
    assign o_out.frame_done = r_o_done;

    assign o_stat.flushing  = w_flushing;
    assign o_stat.done_push = (r_state == S_FOUT) && w_out_free && (r_x == r_fc);

    always_comb begin
        n_state   = r_state;
        n_rows    = r_rows;
        n_col     = r_col;
        n_item    = r_item;
        n_left    = r_left;
        n_x       = r_x;
        n_fc      = r_fc;
        n_fbank   = r_fbank;
        n_o_valid = r_o_valid;
        n_o_next  = r_o_next;
        n_o_done  = r_o_done;
        w_we      = 1'b0;
        if (o_out.ready) begin
            n_o_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_item  = i_q_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!w_have_prev || w_out_free) begin
                    w_we = 1'b1;
                    if (w_have_prev) begin
                        n_o_valid = 1'b1;
                        n_o_done  = 1'b0;
                        n_o_next  = ffa_pkg::next_of(r_rd0,
                            r_left && (r_col != '0),
                            (w_c1 < w_cols) && ffa_pkg::burns(r_rd1),
                            r_item.st == ffa_pkg::ST_BURN);
                    end
                    n_left = ffa_pkg::burns(r_rd0);
                    if (r_item.last) begin
                        n_state = S_FREAD;
                        n_x     = '0;
                        n_fc    = r_col;
                        n_fbank = w_wbank;
                        n_col   = '0;
                        n_rows  = ROWS_FIRST;
                    end else if (w_c1 >= w_cols) begin
                        n_state = S_IDLE;
                        n_col   = '0;
                        n_rows  = (r_rows == ROWS_A) ? ROWS_B : ROWS_A;
                    end else begin
                        n_state = S_IDLE;
                        n_col   = r_col + ffa_pkg::COL_W'(1);
                    end
                end
            end
            S_FREAD: begin
                n_state = S_FOUT;
            end
            S_FOUT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_done  = (r_x == r_fc);
                    n_o_next  = ffa_pkg::next_of(r_rd0,
                        r_left && (r_x != '0),
                        (r_x != r_fc) && ffa_pkg::burns(r_rd1),
                        1'b0);
                    n_left = ffa_pkg::burns(r_rd0);
                    if (r_x == r_fc) begin
                        n_state = S_IDLE;
                    end else begin
                        n_x     = r_x + ffa_pkg::COL_W'(1);
                        n_state = S_FREAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rows    <= ROWS_FIRST;
            r_col     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rows    <= n_rows;
            r_col     <= n_col;
            r_o_valid <= n_o_valid;
        end
        r_item   <= n_item;
        r_left   <= n_left;
        r_x      <= n_x;
        r_fc     <= n_fc;
        r_fbank  <= n_fbank;
        r_o_next <= n_o_next;
        r_o_done <= n_o_done;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_entry;
        end
        r_rd0 <= r_mem[w_ra0];
        r_rd1 <= r_mem[w_ra1];
    end

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ffa_pkg::*;

    // Cell code three is not a named state; the block must treat it as burning.
    localparam logic [1:0] ST_SPARE = 2'd3;
    // Register index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Cycles to let pass after the last expected word: the pipeline holds the front register,
    // the queue and the engine, and cells of a first row leave nothing behind them on the output.
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_ITEMS = 280;

    typedef enum logic {
        PLAN_CELL,
        PLAN_REG
    } plan_kind_t;

    // One row of the directed table: either a register write or one cell word.
    // Rows with 'typed' set carry their results; the others go through the predictor.
    typedef struct packed {
        plan_kind_t       kind;
        t_cfg_idx         reg_idx;
        logic [15:0]      reg_data;
        logic [1:0]       st;
        logic [15:0]      grow;
        logic [15:0]      ignite;
        logic             fe;
        logic             typed;
        logic [2:0]       n_want;
        logic [0:3][1:0]  want;
    } plan_row_t;

    typedef struct packed {
        t_state ns;
        logic   done;
    } next_cell_t;

    localparam int PLAN_LEN = 22;

    logic i_clk;
    logic i_rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0] cfg_data;

    ffa_in_if  cell_in ();
    ffa_out_if gen_out ();

    forest_fire_automaton_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cell_in),
        .o_out       (gen_out),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Predictor state: a copy of the registers and of the two row banks.
    logic [15:0] grow_lim;
    logic [15:0] ign_lim;
    logic [5:0]  cols_reg;
    t_entry      row_bank [0:1][0:MAX_COLS-1];
    int unsigned col_pos;
    int unsigned row_phase;   // 0 first row, then 1 and 2 pick the bank being written
    next_cell_t  gen_buf [0:MAX_COLS];
    int          gen_n;

    next_cell_t  expected_cells [$];
    int          mismatch_count = 0;
    int          random_items = 0;
    int          cycle_count = 0;
    bit          src_idle;
    bit          snk_idle;

    // Directed part. Frame one is a first-row-only frame ending on cell code three;
    // frame two sits exactly on and just past both reset thresholds. After narrowing
    // the row to three cells: a two-row frame that ends early in its second row, then
    // a full two-row frame with thresholds at their extremes.
    plan_row_t plan [0:PLAN_LEN-1] = '{
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_EMPTY, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_TREE,  16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_BURN,  16'h0000, 16'h0000, 1'b0, 1'b1, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_SPARE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 3'd4,
          {ST_TREE, ST_BURN, ST_EMPTY, ST_EMPTY}},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_EMPTY, GROW_THR_RST, 16'hFFFF, 1'b0, 1'b1, 3'd0,
          8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_EMPTY, GROW_THR_RST + 16'd1, 16'h0000, 1'b0, 1'b1,
          3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_TREE, 16'h0000, IGN_THR_RST, 1'b0, 1'b1, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_TREE, 16'h0000, IGN_THR_RST + 16'd1, 1'b1, 1'b1,
          3'd4, {ST_TREE, ST_EMPTY, ST_BURN, ST_TREE}},
        '{PLAN_REG,  CFG_COLS, 16'd3, ST_EMPTY, 16'h0, 16'h0, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_TREE,  16'h1234, 16'hFFFF, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_BURN,  16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_TREE,  16'h0000, 16'hFFFF, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_TREE,  16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_EMPTY, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 3'd0, 8'h00},
        '{PLAN_REG,  CFG_IGNITE, 16'h0000, ST_EMPTY, 16'h0, 16'h0, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_REG,  CFG_GROW, 16'hFFFF, ST_EMPTY, 16'h0, 16'h0, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_EMPTY, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_TREE,  16'hFFFF, 16'h0000, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_TREE,  16'h0000, 16'h0001, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_TREE,  16'h5555, 16'h0001, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_EMPTY, 16'h0000, 16'hAAAA, 1'b0, 1'b0, 3'd0, 8'h00},
        '{PLAN_CELL, CFG_GROW, 16'h0, ST_BURN,  16'hFFFF, 16'h0000, 1'b1, 1'b0, 3'd0, 8'h00}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run; a leftover expectation also ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int unsigned eff_width();
        if (cols_reg < 2) return 2;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return cols_reg;
    endfunction

    function automatic logic on_fire(input t_entry e);
        return e.st == ST_BURN;
    endfunction

    // Update rule for one stored cell, given the burning status of its neighbors.
    function automatic t_state advance_cell(input t_entry e, input logic left,
                                            input logic right, input logic below);
        case (e.st)
            ST_EMPTY: return e.ok ? ST_TREE : ST_EMPTY;
            ST_TREE:  return (e.ok || e.above || left || right || below) ? ST_BURN : ST_TREE;
            default:  return ST_EMPTY;
        endcase
    endfunction

    // Take one accepted cell word; leave the next-generation cells it releases in gen_buf.
    function automatic void step_generation(input logic [1:0] st_in, input logic [15:0] grow,
                                            input logic [15:0] ignite, input logic fe);
        int unsigned width;
        int unsigned c;
        int unsigned wr;
        int unsigned rd;
        int unsigned x;
        logic [1:0]  st;
        logic        have_prev;
        logic        left;
        logic        right;
        t_entry      cur;

        width = eff_width();
        c = col_pos % MAX_COLS;
        wr = (row_phase == 1) ? 1 : 0;
        rd = 1 - wr;
        st = (st_in == ST_SPARE) ? ST_BURN : st_in;
        have_prev = (row_phase != 0);
        gen_n = 0;

        // Classify the incoming cell: draw result and whether the cell above burns.
        cur.st = t_state'(st);
        cur.ok = (st == ST_EMPTY && grow <= grow_lim) || (st == ST_TREE && ignite <= ign_lim);
        cur.above = have_prev && on_fire(row_bank[rd][c]);

        // Release the cell one row up; the incoming cell is its lower neighbor.
        if (have_prev) begin
            left = (c > 0) ? on_fire(row_bank[rd][c - 1]) : 1'b0;
            right = (c + 1 < width && c + 1 < MAX_COLS) ? on_fire(row_bank[rd][c + 1]) : 1'b0;
            gen_buf[0].ns = advance_cell(row_bank[rd][c], left, right, st == ST_BURN);
            gen_buf[0].done = 1'b0;
            gen_n = 1;
        end

        row_bank[wr][c] = cur;

        if (fe) begin
            // Flush the row just written, up to the column received; nothing lies below.
            for (x = 0; x <= c; x++) begin
                left = (x > 0) ? on_fire(row_bank[wr][x - 1]) : 1'b0;
                right = (x < c) ? on_fire(row_bank[wr][x + 1]) : 1'b0;
                gen_buf[gen_n].ns = advance_cell(row_bank[wr][x], left, right, 1'b0);
                gen_buf[gen_n].done = (x == c);
                gen_n++;
            end
            col_pos = 0;
            row_phase = 0;
        end else if (col_pos + 1 >= width) begin
            // A count at or past the last column closes the row, also after narrowing.
            col_pos = 0;
            row_phase = (row_phase == 1) ? 2 : 1;
        end else begin
            col_pos = (col_pos + 1) & 6'h3F;
        end
    endfunction

    // Offer one cell word; on acceptance, queue what it releases. Starts and ends
    // at a falling edge so valid is never lowered and raised in the same step.
    task automatic send_cell(input logic [1:0] st, input logic [15:0] grow,
                             input logic [15:0] ignite, input logic fe, input logic typed,
                             input logic [2:0] n_want, input logic [0:3][1:0] want);
        int gap;
        int k;
        next_cell_t typed_cell;

        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            cell_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cell_in.valid <= 1'b1;
        cell_in.cell_state <= st;
        cell_in.grow_draw <= grow;
        cell_in.ignite_draw <= ignite;
        cell_in.frame_end <= fe;
        do @(posedge i_clk); while (cell_in.ready !== 1'b1);

        step_generation(st, grow, ignite, fe);
        if (typed) begin
            for (k = 0; k < n_want; k++) begin
                typed_cell.ns = t_state'(want[k]);
                typed_cell.done = fe && (k == n_want - 1);
                expected_cells.push_back(typed_cell);
            end
        end else begin
            for (k = 0; k < gen_n; k++) expected_cells.push_back(gen_buf[k]);
        end
        @(negedge i_clk);
    endtask

    // Bias draws toward the threshold edges, with plenty of plain random values.
    function automatic logic [15:0] near_limit(input logic [15:0] lim);
        case ($urandom_range(0, 7))
            0: return lim;
            1: return lim + 16'd1;
            2: return lim - 16'd1;
            3: return 16'h0000;
            4: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_cell(input logic fe);
        logic [1:0] st;
        st = ($urandom_range(0, 9) == 0) ? ST_SPARE : 2'($urandom_range(0, 2));
        send_cell(st, near_limit(grow_lim), near_limit(ign_lim), fe, 1'b0, 3'd0, '0);
        random_items++;
    endtask

    // Hold off the sender until every expected word is back and the pipeline is empty.
    task automatic drain();
        cell_in.valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_GROW:   grow_lim = data;
            CFG_IGNITE: ign_lim = data;
            CFG_COLS:   cols_reg = data[5:0];
            default:    ;
        endcase
        @(negedge i_clk);
    endtask

    // One generation: mostly well-formed frames, some ending early in a later row,
    // some loose runs with frame ends scattered anywhere. Always close the frame.
    task automatic play_frame();
        int w;
        int rows;
        int n;
        int k;
        w = eff_width();
        case ($urandom_range(0, 9))
            0: begin
                n = $urandom_range(1, 3 * w);
                for (k = 0; k < n; k++) random_cell(k == n - 1 || $urandom_range(0, 5) == 0);
            end
            1: begin
                rows = $urandom_range(1, 3);
                n = rows * w + $urandom_range(0, w - 2) + 1;
                for (k = 0; k < n; k++) random_cell(k == n - 1);
            end
            default: begin
                rows = (w > 8) ? 2 : $urandom_range(2, 4);
                n = rows * w;
                for (k = 0; k < n; k++) random_cell(k == n - 1);
            end
        endcase
    endtask

    // Result side: when snk_idle is set, hold ready low for a random gap before each word; check every word.
    initial begin : result_sink
        int stall;
        next_cell_t want;
        gen_out.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = snk_idle ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                gen_out.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            gen_out.ready <= 1'b1;
            do @(posedge i_clk); while (gen_out.valid !== 1'b1);
            if (expected_cells.size() == 0) begin
                flag_mismatch($sformatf("word with nothing expected: state %0d done %0b",
                                        gen_out.next_state, gen_out.frame_done));
            end else begin
                want = expected_cells.pop_front();
                if (gen_out.next_state !== want.ns)
                    flag_mismatch($sformatf("next_state %0d, expected %0d",
                                            gen_out.next_state, want.ns));
                if (gen_out.frame_done !== want.done)
                    flag_mismatch($sformatf("frame_done %0b, expected %0b",
                                            gen_out.frame_done, want.done));
            end
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int i;
        int p;
        int k;
        int n;
        logic [5:0] cols_val;

        // Drive every input to a known value before the first edge.
        i_rst_n = 1'b0;
        cell_in.valid = 1'b0;
        cell_in.cell_state = ST_EMPTY;
        cell_in.grow_draw = '0;
        cell_in.ignite_draw = '0;
        cell_in.frame_end = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_GROW;
        cfg_data = '0;

        // Predictor reset values match the block's register defaults.
        grow_lim = GROW_THR_RST;
        ign_lim = IGN_THR_RST;
        cols_reg = COLS_RST;
        for (i = 0; i < MAX_COLS; i++) begin
            row_bank[0][i] = '0;
            row_bank[1][i] = '0;
        end
        col_pos = 0;
        row_phase = 0;
        src_idle = 1'b1;
        snk_idle = 1'b1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table; register rows wait for the block to go idle first.
        for (i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == PLAN_REG) begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                send_cell(plan[i].st, plan[i].grow, plan[i].ignite, plan[i].fe,
                          plan[i].typed, plan[i].n_want, plan[i].want);
            end
        end

        // Random phases: each one drains, reprograms all registers, then plays frames.
        // Early phases hit the row width extremes; phase four narrows a row mid-frame.
        p = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain();
            case (p)
                0: cols_val = 6'd0;
                1: cols_val = 6'd1;
                2: cols_val = 6'd63;
                3: cols_val = 6'd32;
                4: cols_val = 6'd6;
                default: cols_val = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(7, 20))
                                                                : 6'($urandom_range(2, 6));
            endcase
            // Upper data bits are random; only the low six belong to the width.
            write_reg(CFG_COLS, {10'($urandom), cols_val});
            case (p % 4)
                0: write_reg(CFG_GROW, 16'h0000);
                1: write_reg(CFG_GROW, 16'hFFFF);
                2: write_reg(CFG_GROW, 16'($urandom));
                default: write_reg(CFG_GROW, GROW_THR_RST);
            endcase
            case ((p + 1) % 4)
                0: write_reg(CFG_IGNITE, 16'h0000);
                1: write_reg(CFG_IGNITE, 16'hFFFF);
                2: write_reg(CFG_IGNITE, 16'($urandom));
                default: write_reg(CFG_IGNITE, IGN_THR_RST);
            endcase
            if (p == 5) write_reg(CFG_SPARE, 16'($urandom));

            // Vary the idling so some phases run back to back on either side.
            src_idle = (p % 3 != 1);
            snk_idle = (p % 4 != 2);

            if (p == 4) begin
                // One full row and four cells into the next, then narrow the row:
                // the next cell is past the new last column and closes the row.
                for (k = 0; k < 10; k++) random_cell(1'b0);
                drain();
                write_reg(CFG_COLS, 16'($urandom_range(2, 4)));
                n = 1 + 2 * eff_width();
                for (k = 0; k < n; k++) random_cell(k == n - 1);
            end else if (eff_width() > 8) begin
                play_frame();
            end else begin
                repeat ($urandom_range(1, 3)) play_frame();
            end
            p++;
        end

        drain();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
